// ===== hdl/assert_macros.svh =====
// Assertion macros used by the queue sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge out of reset.
`define ASSERT_ALWAYS(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fmbq_pkg.sv =====
// Package: command and status codes, sequencer states and result type.
`timescale 1ns / 1ps
package fmbq_pkg;

  localparam int VW = 32;

  localparam logic [2:0] CMD_ADD_FRONT  = 3'd0;
  localparam logic [2:0] CMD_ADD_REAR   = 3'd1;
  localparam logic [2:0] CMD_ADD_MIDDLE = 3'd2;
  localparam logic [2:0] CMD_REM_FRONT  = 3'd3;
  localparam logic [2:0] CMD_REM_REAR   = 3'd4;
  localparam logic [2:0] CMD_REM_MIDDLE = 3'd5;
  localparam logic [2:0] CMD_PEEK       = 3'd6;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic signed [VW-1:0] NEG_ONE = -32'sd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_TAKE_RD,
    ST_TAKE_CAP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_RB_FRONT,
    ST_RB_REAR,
    ST_RB_MID,
    ST_RB_LAST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [VW-1:0] removed_value;
    logic signed [VW-1:0] front_value;
    logic signed [VW-1:0] rear_value;
    logic signed [VW-1:0] middle_value;
    logic [3:0]           count;
  } result_t;

endpackage

// ===== hdl/fmbq_ram.sv =====
// Element store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module fmbq_ram import fmbq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [VW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [VW-1:0]            rdata
);

  logic [VW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/fmbq_ctrl.sv =====
// Sequencer: decodes a command, moves elements through the shared slot adder,
// then reads back front, rear and middle unless the queue is empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fmbq_ctrl import fmbq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               command,
  input  logic signed [VW-1:0]     value_in,
  output logic                     res_valid,
  input  logic                     res_take,
  output result_t                  res,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [VW-1:0]            mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [VW-1:0]            mem_rdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CXW = (IW > 4) ? IW : 4;
  localparam logic [IW:0]   DEPTH_W = (IW+1)'(DEPTH);
  localparam logic [IW-1:0] LAST    = IW'(DEPTH - 1);

  state_t state, state_next;

  logic [2:0]           cmd, cmd_next;
  logic signed [VW-1:0] val, val_next;
  logic [IW-1:0]        n, n_next;
  logic [IW-1:0]        head, head_next;
  logic [IW-1:0]        tail, tail_next;
  logic [IW-1:0]        pos, pos_next;
  logic [IW-1:0]        lim, lim_next;
  logic [1:0]           status_r, status_next;
  logic signed [VW-1:0] removed, removed_next;
  logic signed [VW-1:0] front, front_next;
  logic signed [VW-1:0] rear, rear_next;
  logic signed [VW-1:0] mid, mid_next;

  // shared slot unit: (head + offset) mod DEPTH
  logic [IW-1:0] slot_pos, slot;
  logic [IW:0]   slot_sum, slot_wrap;

  assign slot_sum  = {1'b0, head} + {1'b0, slot_pos};
  assign slot_wrap = slot_sum - DEPTH_W;
  assign slot      = (slot_sum >= DEPTH_W) ? slot_wrap[IW-1:0] : slot_sum[IW-1:0];

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] x);
    return (x == LAST) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IW-1:0] dec_idx(input logic [IW-1:0] x);
    return (x == '0) ? LAST : x - 1'b1;
  endfunction

  logic          is_add, is_rem, full, empty, shift_up;
  logic [IW-1:0] half;
  logic          more_down, more_down_wr, more_up_wr;

  assign is_add       = (cmd == CMD_ADD_FRONT) || (cmd == CMD_ADD_REAR) ||
                        (cmd == CMD_ADD_MIDDLE);
  assign is_rem       = (cmd == CMD_REM_FRONT) || (cmd == CMD_REM_REAR) ||
                        (cmd == CMD_REM_MIDDLE);
  assign full         = (n == LAST);
  assign empty        = (n == '0);
  assign shift_up     = (cmd == CMD_ADD_MIDDLE);
  assign half         = n >> 1;
  assign more_down    = ({1'b0, pos} + (IW+1)'(1)) < {1'b0, n};
  assign more_down_wr = ({1'b0, pos} + (IW+1)'(2)) < {1'b0, n};
  assign more_up_wr   = (pos - 1'b1) > lim;

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      n     <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      n     <= n_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    val      <= val_next;
    pos      <= pos_next;
    lim      <= lim_next;
    status_r <= status_next;
    removed  <= removed_next;
    front    <= front_next;
    rear     <= rear_next;
    mid      <= mid_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (is_add) begin
          if (!full && shift_up) begin
            state_next = (half != '0) ? ST_SHIFT_RD : ST_PUT;
          end else begin
            state_next = ST_RB_FRONT;
          end
        end else if (is_rem && !empty) begin
          state_next = ST_TAKE_RD;
        end else begin
          state_next = ST_RB_FRONT;
        end
      end
      ST_TAKE_RD:  state_next = ST_TAKE_CAP;
      ST_TAKE_CAP: begin
        state_next = ((cmd == CMD_REM_MIDDLE) && more_down) ? ST_SHIFT_RD : ST_RB_FRONT;
      end
      ST_SHIFT_RD: state_next = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        if (shift_up) begin
          state_next = more_up_wr ? ST_SHIFT_RD : ST_PUT;
        end else begin
          state_next = more_down_wr ? ST_SHIFT_RD : ST_RB_FRONT;
        end
      end
      ST_PUT:      state_next = ST_RB_FRONT;
      ST_RB_FRONT: state_next = empty ? ST_DONE : ST_RB_REAR;
      ST_RB_REAR:  state_next = ST_RB_MID;
      ST_RB_MID:   state_next = ST_RB_LAST;
      ST_RB_LAST:  state_next = ST_DONE;
      ST_DONE: begin
        if (res_take) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_next     = cmd;
    val_next     = val;
    n_next       = n;
    head_next    = head;
    tail_next    = tail;
    pos_next     = pos;
    lim_next     = lim;
    status_next  = status_r;
    removed_next = removed;
    front_next   = front;
    rear_next    = rear;
    mid_next     = mid;
    slot_pos     = pos;
    mem_we       = 1'b0;
    mem_waddr    = slot;
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = slot;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_next     = command;
          val_next     = value_in;
          status_next  = STAT_DONE;
          removed_next = NEG_ONE;
        end
      end
      ST_DECIDE: begin
        if (is_add) begin
          if (full) begin
            status_next = STAT_FULL;
          end else if (cmd == CMD_ADD_FRONT) begin
            mem_we    = 1'b1;
            mem_waddr = dec_idx(head);
            mem_wdata = val;
            head_next = dec_idx(head);
            n_next    = n + 1'b1;
          end else if (cmd == CMD_ADD_REAR) begin
            mem_we    = 1'b1;
            mem_waddr = tail;
            mem_wdata = val;
            tail_next = inc_idx(tail);
            n_next    = n + 1'b1;
          end else begin
            pos_next = n;
            lim_next = n - half;
          end
        end else if (is_rem) begin
          if (empty) begin
            status_next = STAT_EMPTY;
          end else if (cmd == CMD_REM_FRONT) begin
            pos_next = '0;
          end else if (cmd == CMD_REM_REAR) begin
            pos_next = n - 1'b1;
          end else begin
            pos_next = half;
          end
        end
      end
      ST_TAKE_RD: begin
        mem_re = 1'b1;
      end
      ST_TAKE_CAP: begin
        removed_next = mem_rdata;
        if (cmd == CMD_REM_FRONT) begin
          head_next = inc_idx(head);
          n_next    = n - 1'b1;
        end else if ((cmd == CMD_REM_REAR) || !more_down) begin
          tail_next = dec_idx(tail);
          n_next    = n - 1'b1;
        end
      end
      ST_SHIFT_RD: begin
        mem_re   = 1'b1;
        slot_pos = shift_up ? pos - 1'b1 : pos + 1'b1;
      end
      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        pos_next  = shift_up ? pos - 1'b1 : pos + 1'b1;
        if (!shift_up && !more_down_wr) begin
          tail_next = dec_idx(tail);
          n_next    = n - 1'b1;
        end
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        slot_pos  = lim;
        mem_wdata = val;
        tail_next = inc_idx(tail);
        n_next    = n + 1'b1;
      end
      ST_RB_FRONT: begin
        if (empty) begin
          front_next = NEG_ONE;
          rear_next  = NEG_ONE;
          mid_next   = NEG_ONE;
        end else begin
          mem_re   = 1'b1;
          slot_pos = '0;
        end
      end
      ST_RB_REAR: begin
        front_next = mem_rdata;
        mem_re     = 1'b1;
        slot_pos   = n - 1'b1;
      end
      ST_RB_MID: begin
        rear_next = mem_rdata;
        mem_re    = 1'b1;
        slot_pos  = half;
      end
      ST_RB_LAST: begin
        mid_next = mem_rdata;
      end
      default: begin
      end
    endcase
  end

  logic [CXW-1:0] cnt_ext;
  assign cnt_ext = CXW'(n);

  always_comb begin
    res.status        = status_r;
    res.removed_value = removed;
    res.front_value   = front;
    res.rear_value    = rear;
    res.middle_value  = mid;
    res.count         = cnt_ext[3:0];
  end

  // occupancy check: n must equal (tail - head) mod DEPTH
  logic [IW:0]   occ_dist, occ_wrap;
  logic [IW-1:0] occ_chk;
  assign occ_dist = {1'b0, tail} + DEPTH_W - {1'b0, head};
  assign occ_wrap = occ_dist - DEPTH_W;
  assign occ_chk  = (occ_dist >= DEPTH_W) ? occ_wrap[IW-1:0] : occ_dist[IW-1:0];

  `ASSERT_ALWAYS(a_occ_match, clk, rst, occ_chk == n, "count out of step with head and tail")
  `ASSERT_NEXT(a_full_reject, clk, rst, (state == ST_DECIDE) && is_add && full, (status_r == STAT_FULL) && (n == LAST), "full add changed the queue")
  `ASSERT_IMPL(a_no_late_write, clk, rst, (state == ST_RB_FRONT) || (state == ST_RB_REAR) || (state == ST_RB_MID) || (state == ST_RB_LAST) || (state == ST_DONE), !mem_we, "store written during readback")

endmodule

// ===== hdl/front_middle_back_queue.sv =====
// Top level: queue with front, middle and rear access and a result register.
//
// Input channel (in_valid/in_ready, command, value_in) takes one command per
// transfer; output channel (out_valid/out_ready) returns one result per command
// with status, removed value, front/rear/middle values and count.
// Items are processed one at a time. A middle add or a middle removal moves k
// elements, where k is about count/2. When the queue is empty afterwards the
// readback is skipped. Each element move is a read then a write of the element
// store (one write port, one read port) through one shared slot-address adder.
// in_ready is high only while the sequencer is idle; it rises with out_valid
// when the result register is free. The result register holds a finished
// result while the receiver stalls and the next command is accepted meanwhile;
// a second result waits in the sequencer until the register frees up.
// Reset (rst, synchronous) empties the queue: head, tail and count go to zero
// and both channels go idle. Stored elements are not cleared.
`timescale 1ns / 1ps
module front_middle_back_queue import fmbq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           command,
  input  logic signed [VW-1:0] value_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic signed [VW-1:0] removed_value,
  output logic signed [VW-1:0] front_value,
  output logic signed [VW-1:0] rear_value,
  output logic signed [VW-1:0] middle_value,
  output logic [3:0]           count
);

  localparam int IW = $clog2(DEPTH);

  logic          res_valid, res_take;
  result_t       res, out_r;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [VW-1:0] mem_wdata, mem_rdata;

  fmbq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .value_in  (value_in),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  fmbq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign status        = out_r.status;
  assign removed_value = out_r.removed_value;
  assign front_value   = out_r.front_value;
  assign rear_value    = out_r.rear_value;
  assign middle_value  = out_r.middle_value;
  assign count         = out_r.count;

endmodule

// ===== verif/front_middle_back_queue_test.sv =====
// Self-checking testbench for front_middle_back_queue.
`timescale 1ns / 1ps
module front_middle_back_queue_test import fmbq_pkg::*; ();

  localparam int QDEPTH = 16;
  localparam logic [2:0] CMD_SPARE = 3'd7;

  typedef struct {
    logic [2:0]           cmd;
    logic signed [VW-1:0] val;
    int                   gap;
    bit                   drain;   // hold until every pending result is back
  } cmd_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           command = CMD_PEEK;
  logic signed [VW-1:0] value_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  logic signed [VW-1:0] removed_value;
  logic signed [VW-1:0] front_value;
  logic signed [VW-1:0] rear_value;
  logic signed [VW-1:0] middle_value;
  logic [3:0]           count;

  front_middle_back_queue #(.DEPTH(QDEPTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .value_in(value_in),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .removed_value(removed_value), .front_value(front_value), .rear_value(rear_value),
    .middle_value(middle_value), .count(count)
  );

  initial forever #6 clk = ~clk;

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Shadow copy of the queue
  logic signed [VW-1:0] shadow_store [QDEPTH];
  int                   shadow_head = 0;
  int                   shadow_tail = 0;

  cmd_item_t pending_cmds [$];
  result_t   expected_results [$];
  int        mismatch_count = 0;
  int        results_seen = 0;

  initial foreach (shadow_store[k]) shadow_store[k] = '0;

  function automatic int slot_at(int pos);
    return (shadow_head + pos) % QDEPTH;
  endfunction

  function automatic result_t apply_queue_command(logic [2:0] cmd, logic signed [VW-1:0] val);
    result_t r;
    int      n;
    int      p;
    int      i;
    n = (shadow_tail + QDEPTH - shadow_head) % QDEPTH;
    r.status = STAT_DONE;
    r.removed_value = NEG_ONE;
    case (cmd)
      CMD_ADD_FRONT, CMD_ADD_REAR, CMD_ADD_MIDDLE: begin
        if (n >= QDEPTH - 1) begin
          r.status = STAT_FULL;
        end else if (cmd == CMD_ADD_FRONT) begin
          shadow_head = (shadow_head + QDEPTH - 1) % QDEPTH;
          shadow_store[shadow_head] = val;
        end else if (cmd == CMD_ADD_REAR) begin
          shadow_store[shadow_tail] = val;
          shadow_tail = (shadow_tail + 1) % QDEPTH;
        end else begin
          p = n - n / 2;
          for (i = n; i > p; i--) shadow_store[slot_at(i)] = shadow_store[slot_at(i - 1)];
          shadow_store[slot_at(p)] = val;
          shadow_tail = (shadow_tail + 1) % QDEPTH;
        end
      end
      CMD_REM_FRONT, CMD_REM_REAR, CMD_REM_MIDDLE: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else if (cmd == CMD_REM_FRONT) begin
          r.removed_value = shadow_store[shadow_head];
          shadow_head = (shadow_head + 1) % QDEPTH;
        end else if (cmd == CMD_REM_REAR) begin
          shadow_tail = (shadow_tail + QDEPTH - 1) % QDEPTH;
          r.removed_value = shadow_store[shadow_tail];
        end else begin
          p = n / 2;
          r.removed_value = shadow_store[slot_at(p)];
          for (i = p; i + 1 < n; i++) shadow_store[slot_at(i)] = shadow_store[slot_at(i + 1)];
          shadow_tail = (shadow_tail + QDEPTH - 1) % QDEPTH;
        end
      end
      default: ;  // peek and the spare code leave the queue alone
    endcase
    n = (shadow_tail + QDEPTH - shadow_head) % QDEPTH;
    if (n == 0) begin
      r.front_value  = NEG_ONE;
      r.rear_value   = NEG_ONE;
      r.middle_value = NEG_ONE;
    end else begin
      r.front_value  = shadow_store[shadow_head];
      r.rear_value   = shadow_store[slot_at(n - 1)];
      r.middle_value = shadow_store[slot_at(n / 2)];
    end
    r.count = n[3:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [VW-1:0] got, logic [VW-1:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", results_seen, field, got, want);
    mismatch_count++;
  endtask

  // Handshake flags seen at the last rising edge
  logic in_fire = 1'b0;
  logic out_taken = 1'b0;

  always @(posedge clk) begin : check_results
    result_t want;
    in_fire   <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", VW'(status), '0);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", VW'(status), VW'(want.status));
        if (removed_value !== want.removed_value)
          report_mismatch("removed_value", removed_value, want.removed_value);
        if (front_value !== want.front_value)
          report_mismatch("front_value", front_value, want.front_value);
        if (rear_value !== want.rear_value)
          report_mismatch("rear_value", rear_value, want.rear_value);
        if (middle_value !== want.middle_value)
          report_mismatch("middle_value", middle_value, want.middle_value);
        if (count !== want.count) report_mismatch("count", VW'(count), VW'(want.count));
      end
      results_seen++;
    end
    if (!rst && in_valid && in_ready)
      expected_results.push_back(apply_queue_command(command, value_in));
  end

  // Command driver
  cmd_item_t drv_item;
  bit        drv_loaded = 1'b0;
  int        drv_wait = 0;

  always @(negedge clk) begin : drive_commands
    logic nxt_valid;
    if (!rst) begin
      nxt_valid = in_valid && !in_fire;
      if (!nxt_valid) begin
        if (!drv_loaded && pending_cmds.size() != 0) begin
          drv_item   = pending_cmds.pop_front();
          drv_wait   = drv_item.gap;
          drv_loaded = 1'b1;
        end
        if (drv_loaded && !(drv_item.drain && expected_results.size() != 0)) begin
          if (drv_wait > 0) begin
            drv_wait--;
          end else begin
            nxt_valid  = 1'b1;
            command   <= drv_item.cmd;
            value_in  <= drv_item.val;
            drv_loaded = 1'b0;
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Result receiver: random stalls, stall-free stretches, and two long hold-offs
  int rx_taken = 0;
  int rx_stall = 0;

  always @(negedge clk) begin : accept_results
    if (!rst) begin
      if (out_taken) begin
        rx_taken++;
        if (rx_taken == 60 || rx_taken == 800) rx_stall = 250;
        else if ((rx_taken / 200) % 3 == 1) rx_stall = 0;
        else rx_stall = $urandom_range(0, 13);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [VW-1:0] draw_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return NEG_ONE;
      4, 5:    return $signed($urandom_range(0, 255)) - 128;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_cmd(logic [2:0] cmd, logic signed [VW-1:0] val, int gap, bit drain);
    cmd_item_t it;
    it.cmd   = cmd;
    it.val   = val;
    it.gap   = gap;
    it.drain = drain;
    pending_cmds.push_back(it);
  endtask

  initial begin : stimulus
    int          bias;
    int          roll;
    int          gap;
    logic [2:0]  cmd;

    // Empty queue: peeks and rejected removals
    queue_cmd(CMD_PEEK, 32'sh12345678, 0, 1'b0);
    queue_cmd(CMD_SPARE, 32'sh7FFFFFFF, 0, 1'b0);
    queue_cmd(CMD_REM_FRONT, '0, $urandom_range(0, 13), 1'b0);
    queue_cmd(CMD_REM_REAR, '0, 0, 1'b0);
    queue_cmd(CMD_REM_MIDDLE, '0, $urandom_range(0, 13), 1'b0);
    // Middle adds into empty and one-element queues, then adds until full
    queue_cmd(CMD_ADD_MIDDLE, 32'sh7FFFFFFF, 0, 1'b0);
    queue_cmd(CMD_ADD_MIDDLE, 32'sh80000000, 0, 1'b0);
    queue_cmd(CMD_ADD_FRONT, NEG_ONE, $urandom_range(0, 13), 1'b0);
    queue_cmd(CMD_ADD_REAR, '0, 0, 1'b0);
    for (int i = 0; i < 11; i++) begin
      cmd = (i % 3 == 0) ? CMD_ADD_MIDDLE : (i % 3 == 1) ? CMD_ADD_FRONT : CMD_ADD_REAR;
      queue_cmd(cmd, draw_value(), $urandom_range(0, 13), 1'b0);
    end
    // Full: every add is turned away, then one removal of each kind
    queue_cmd(CMD_ADD_FRONT, 32'sh55555555, 0, 1'b0);
    queue_cmd(CMD_ADD_REAR, 32'shAAAAAAAA, 0, 1'b0);
    queue_cmd(CMD_ADD_MIDDLE, 32'sh0F0F0F0F, $urandom_range(0, 13), 1'b0);
    queue_cmd(CMD_REM_MIDDLE, '0, 0, 1'b0);
    queue_cmd(CMD_REM_REAR, '0, 0, 1'b0);
    queue_cmd(CMD_REM_FRONT, '0, 0, 1'b0);

    // Random walks, biased toward filling, draining or neither per phase
    for (int ph = 0; ph < 36; ph++) begin
      bias = $urandom_range(0, 2);
      for (int k = 0; k < 40; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < ((bias == 0) ? 70 : (bias == 1) ? 25 : 45))
          cmd = 3'(CMD_ADD_FRONT + $urandom_range(0, 2));
        else if (roll < 94)
          cmd = 3'(CMD_REM_FRONT + $urandom_range(0, 2));
        else
          cmd = $urandom_range(0, 1) ? CMD_PEEK : CMD_SPARE;
        gap = (ph % 4 == 3) ? 0 : $urandom_range(0, 13);
        queue_cmd(cmd, draw_value(), gap, k == 0 && ph % 9 == 0);
      end
    end

    while (pending_cmds.size() != 0 || drv_loaded || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fmbq_pkg.sv
hdl/fmbq_ram.sv
hdl/fmbq_ctrl.sv
hdl/front_middle_back_queue.sv
verif/front_middle_back_queue_test.sv
